@@ rtl/sbfb_pkg.sv @@
// Shared widths, register indexes and beat types of the spot beam falloff blend.
package sbfb_pkg;

  localparam int COORD_BITS       = 11;
  localparam int AMOUNT_FRAC_BITS = 8;
  localparam int DIST_FRAC_BITS   = 4;
  localparam int COL_W            = 8;
  localparam int ACC_W            = 12;
  localparam int IDX_W            = 3;
  localparam int QDEPTH           = 4;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int PROD_W = 2 * SQ_W;
  localparam int QUO_W  = SQ_W + 2 * DIST_FRAC_BITS;
  localparam int ROOT_W = (QUO_W + 1) / 2;
  localparam int RAD_W  = COORD_BITS + DIST_FRAC_BITS;
  localparam int AMT_W  = AMOUNT_FRAC_BITS + 1;
  localparam int DATA_W = COORD_BITS;

  localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(2 ** AMOUNT_FRAC_BITS);

  typedef enum logic [IDX_W-1:0] {
    REG_SPOT_X,
    REG_SPOT_Y,
    REG_INNER_RADIUS,
    REG_OUTER_RADIUS,
    REG_SPOT_RED,
    REG_SPOT_GREEN,
    REG_SPOT_BLUE,
    REG_BLEND_SUBTRACT
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   beam_start_x;
    logic [COORD_BITS-1:0]   beam_start_y;
    logic [COORD_BITS-1:0]   beam_end_x;
    logic [COORD_BITS-1:0]   beam_end_y;
    logic signed [ACC_W-1:0] acc_red;
    logic signed [ACC_W-1:0] acc_green;
    logic signed [ACC_W-1:0] acc_blue;
  } beam_t;

  typedef struct packed {
    logic [AMT_W-1:0]        falloff_amount;
    logic signed [ACC_W-1:0] new_red;
    logic signed [ACC_W-1:0] new_green;
    logic signed [ACC_W-1:0] new_blue;
    logic [COL_W-1:0]        out_red;
    logic [COL_W-1:0]        out_green;
    logic [COL_W-1:0]        out_blue;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] spot_x;
    logic [COORD_BITS-1:0] spot_y;
    logic [COORD_BITS-1:0] inner_radius;
    logic [COORD_BITS-1:0] outer_radius;
    logic [COL_W-1:0]      spot_red;
    logic [COL_W-1:0]      spot_green;
    logic [COL_W-1:0]      spot_blue;
    logic                  blend_subtract;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] red;
    logic signed [ACC_W-1:0] green;
    logic signed [ACC_W-1:0] blue;
  } acc_t;

  typedef struct packed {
    logic                     seg;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [SQ_W-1:0]          crs_abs;
    logic [SQ_W-1:0]          len;
    acc_t                     acc;
  } fq_t;

endpackage

@@ rtl/sbfb_front.sv @@
// Front part: takes beams, forms the projection terms and classifies the closest point.
module sbfb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           beam_valid,
  output logic           beam_ready,
  input  sbfb_pkg::beam_t beam,
  input  sbfb_pkg::cfg_t  cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output sbfb_pkg::fq_t   push_data
);
  import sbfb_pkg::*;

  logic                     f_vld;
  logic signed [DIFF_W-1:0] a, b, c, d, e, f;
  acc_t                     acc;
  logic signed [2*DIFF_W:0] dot, len, crs, crs_mag;
  logic                     push;

  assign push       = f_vld && push_ready;
  assign beam_ready = !f_vld || push_ready;
  assign push_valid = f_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (beam_valid && beam_ready) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beam_valid && beam_ready) begin
      a <= $signed({1'b0, cfg.spot_x}) - $signed({1'b0, beam.beam_start_x});
      b <= $signed({1'b0, cfg.spot_y}) - $signed({1'b0, beam.beam_start_y});
      c <= $signed({1'b0, beam.beam_end_x}) - $signed({1'b0, beam.beam_start_x});
      d <= $signed({1'b0, beam.beam_end_y}) - $signed({1'b0, beam.beam_start_y});
      e <= $signed({1'b0, cfg.spot_x}) - $signed({1'b0, beam.beam_end_x});
      f <= $signed({1'b0, cfg.spot_y}) - $signed({1'b0, beam.beam_end_y});
      acc.red   <= beam.acc_red;
      acc.green <= beam.acc_green;
      acc.blue  <= beam.acc_blue;
    end
  end

  always_comb begin
    dot     = a * c + b * d;
    len     = c * c + d * d;
    crs     = a * d - b * c;
    crs_mag = crs[2*DIFF_W] ? -crs : crs;
    push_data.crs_abs = crs_mag[SQ_W-1:0];
    push_data.len     = len[SQ_W-1:0];
    push_data.acc     = acc;
    push_data.seg     = 1'b0;
    push_data.dx      = a;
    push_data.dy      = b;
    if (len == '0 || dot[2*DIFF_W] || dot == '0) begin
      push_data.seg = 1'b0;
    end else if (dot >= len) begin
      push_data.dx = e;
      push_data.dy = f;
    end else begin
      push_data.seg = 1'b1;
    end
  end

endmodule

@@ rtl/sbfb_queue.sv @@
// Short first-in first-out queue between the front and back parts.
module sbfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  sbfb_pkg::fq_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sbfb_pkg::fq_t pop_data
);
  import sbfb_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  fq_t              mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign push_ready = count != (PTR_W+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/sbfb_back.sv @@
// Back part: quotient, root and amount pipelines, then the colour blend and output register.
module sbfb_back (
  input  logic             clk,
  input  logic             rst,
  input  sbfb_pkg::cfg_t   cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  sbfb_pkg::fq_t    pop_data,
  output logic             result_valid,
  input  logic             result_ready,
  output sbfb_pkg::result_t result
);
  import sbfb_pkg::*;

  localparam logic signed [ACC_W+1:0] ACC_HI = (ACC_W+2)'(2 ** (ACC_W - 1) - 1);
  localparam logic signed [ACC_W+1:0] ACC_LO = -(ACC_W+2)'(2 ** (ACC_W - 1));
  localparam logic signed [ACC_W+1:0] COL_HI = (ACC_W+2)'(2 ** COL_W - 1);

  typedef struct packed {
    logic            seg;
    logic [SQ_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [SQ_W-1:0] den;
    acc_t            acc;
  } dv_t;

  typedef struct packed {
    logic [2*ROOT_W:0] rem;
    logic [ROOT_W-1:0] root;
    acc_t              acc;
  } sr_t;

  typedef struct packed {
    logic             full;
    logic             zero;
    logic [RAD_W-1:0] rem;
    logic [AMT_W-1:0] lo;
    logic [RAD_W-1:0] den;
    acc_t             acc;
  } am_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] new_v;
    logic [COL_W-1:0]        out_v;
  } chan_t;

  function automatic chan_t blend(input logic signed [ACC_W-1:0] acc,
                                  input logic [COL_W-1:0] spot,
                                  input logic [AMT_W-1:0] amt,
                                  input logic sub);
    logic [COL_W+AMT_W-1:0]  prod;
    logic signed [ACC_W+1:0] sc;
    logic signed [ACC_W+1:0] nv;
    chan_t                   r;
    prod = spot * amt;
    sc   = $signed((ACC_W+2)'(prod[COL_W+AMT_W-1:AMOUNT_FRAC_BITS]));
    nv   = sub ? (ACC_W+2)'(acc) - sc : (ACC_W+2)'(acc) + sc;
    if (nv > ACC_HI) begin
      r.new_v = ACC_HI[ACC_W-1:0];
    end else if (nv < ACC_LO) begin
      r.new_v = ACC_LO[ACC_W-1:0];
    end else begin
      r.new_v = nv[ACC_W-1:0];
    end
    if (nv > COL_HI) begin
      r.out_v = '1;
    end else if (nv[ACC_W+1]) begin
      r.out_v = '0;
    end else begin
      r.out_v = nv[COL_W-1:0];
    end
    return r;
  endfunction

  logic                      en;
  logic [QUO_W:0]            dv_vld;
  dv_t                       dv [QUO_W+1];
  logic [ROOT_W:0]           sr_vld;
  sr_t                       sr [ROOT_W+1];
  logic [AMT_W:0]            am_vld;
  am_t                       am [AMT_W+1];
  logic [PROD_W-1:0]         prod;
  logic signed [2*DIFF_W:0]  esq;
  logic [PROD_W+2*DIST_FRAC_BITS-1:0] num;
  dv_t                       dv0_next;
  am_t                       am0_next;
  logic [RAD_W-1:0]          ri, ro, anum;
  logic [RAD_W+AMOUNT_FRAC_BITS-1:0] adiv;
  logic [ROOT_W-1:0]         d4;
  logic [AMT_W-1:0]          amt;
  chan_t                     ch_r, ch_g, ch_b;

  assign en           = !result_valid || result_ready;
  assign pop_ready    = en;

  always_comb begin
    prod = pop_data.crs_abs * pop_data.crs_abs;
    esq  = pop_data.dx * pop_data.dx + pop_data.dy * pop_data.dy;
    num  = {prod, {(2*DIST_FRAC_BITS){1'b0}}};
    dv0_next.seg = pop_data.seg;
    dv0_next.den = pop_data.len;
    dv0_next.acc = pop_data.acc;
    if (pop_data.seg) begin
      dv0_next.rem = num[PROD_W+2*DIST_FRAC_BITS-1:QUO_W];
      dv0_next.lo  = num[QUO_W-1:0];
    end else begin
      dv0_next.rem = '0;
      dv0_next.lo  = {esq[SQ_W-1:0], {(2*DIST_FRAC_BITS){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    logic [SQ_W:0] t;
    logic          ge;
    dv_t           nxt;
    always_comb begin
      t   = {dv[i].rem, dv[i].lo[QUO_W-1]};
      ge  = t >= {1'b0, dv[i].den};
      nxt = dv[i];
      if (dv[i].seg) begin
        nxt.rem = ge ? SQ_W'(t - {1'b0, dv[i].den}) : t[SQ_W-1:0];
        nxt.lo  = {dv[i].lo[QUO_W-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else if (en) begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    sr_vld[0]   = dv_vld[QUO_W];
    sr[0].rem   = (2*ROOT_W+1)'(dv[QUO_W].lo);
    sr[0].root  = '0;
    sr[0].acc   = dv[QUO_W].acc;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    localparam int B = ROOT_W - 1 - i;
    logic [2*ROOT_W:0] term;
    logic              ge;
    sr_t               nxt;
    always_comb begin
      term = ((2*ROOT_W+1)'(sr[i].root) << (B + 1)) + ((2*ROOT_W+1)'(1) << (2 * B));
      ge   = sr[i].rem >= term;
      nxt  = sr[i];
      if (ge) begin
        nxt.rem     = sr[i].rem - term;
        nxt.root[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sr_vld[i+1] <= 1'b0;
      end else if (en) begin
        sr_vld[i+1] <= sr_vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    d4   = sr[ROOT_W].root;
    ri   = {cfg.inner_radius, {DIST_FRAC_BITS{1'b0}}};
    ro   = {cfg.outer_radius, {DIST_FRAC_BITS{1'b0}}};
    anum = ro - d4[RAD_W-1:0];
    adiv = {anum, {AMOUNT_FRAC_BITS{1'b0}}};
    am0_next.zero = !(d4 < ROOT_W'(ri)) && (d4 > ROOT_W'(ro));
    am0_next.full = (d4 < ROOT_W'(ri)) || (!am0_next.zero && ro == ri);
    am0_next.rem  = RAD_W'(adiv[RAD_W+AMOUNT_FRAC_BITS-1:AMT_W]);
    am0_next.lo   = adiv[AMT_W-1:0];
    am0_next.den  = ro - ri;
    am0_next.acc  = sr[ROOT_W].acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      am_vld[0] <= 1'b0;
    end else if (en) begin
      am_vld[0] <= sr_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am[0] <= am0_next;
    end
  end

  for (genvar i = 0; i < AMT_W; i++) begin : g_amt
    logic [RAD_W:0] t;
    logic           ge;
    am_t            nxt;
    always_comb begin
      t       = {am[i].rem, am[i].lo[AMT_W-1]};
      ge      = t >= {1'b0, am[i].den};
      nxt     = am[i];
      nxt.rem = ge ? RAD_W'(t - {1'b0, am[i].den}) : t[RAD_W-1:0];
      nxt.lo  = {am[i].lo[AMT_W-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        am_vld[i+1] <= 1'b0;
      end else if (en) begin
        am_vld[i+1] <= am_vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        am[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    if (am[AMT_W].full) begin
      amt = AMT_ONE;
    end else if (am[AMT_W].zero) begin
      amt = '0;
    end else begin
      amt = am[AMT_W].lo;
    end
    ch_r = blend(am[AMT_W].acc.red, cfg.spot_red, amt, cfg.blend_subtract);
    ch_g = blend(am[AMT_W].acc.green, cfg.spot_green, amt, cfg.blend_subtract);
    ch_b = blend(am[AMT_W].acc.blue, cfg.spot_blue, amt, cfg.blend_subtract);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= am_vld[AMT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.falloff_amount <= amt;
      result.new_red        <= ch_r.new_v;
      result.new_green      <= ch_g.new_v;
      result.new_blue       <= ch_b.new_v;
      result.out_red        <= ch_r.out_v;
      result.out_green      <= ch_g.out_v;
      result.out_blue       <= ch_b.out_v;
    end
  end

endmodule

@@ rtl/spot_beam_falloff_blend.sv @@
// Top level of the spot beam falloff blend: configuration registers, front, queue and back.
//
//   channel   direction  handshake               payload
//   beam      in         beam_valid/beam_ready    beam (beam_t)
//   result    out        result_valid/result_ready result (result_t)
//   cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One beam is taken per cycle while the queue has room; each passes through the
// 31-stage quotient pipeline, the 16-stage root pipeline and the 9-stage amount divider.
// Reset clears the configuration registers to zero and empties every stage.
// The back pipeline stalls as a whole while a result beat waits; a four-beat queue lets
// the front keep taking beams meanwhile.
module spot_beam_falloff_blend (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           beam_valid,
  output logic                           beam_ready,
  input  sbfb_pkg::beam_t                beam,
  output logic                           result_valid,
  input  logic                           result_ready,
  output sbfb_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbfb_pkg::IDX_W-1:0]     cfg_index,
  input  logic [sbfb_pkg::DATA_W-1:0]    cfg_data
);
  import sbfb_pkg::*;

  cfg_t cfg;
  logic push_valid, push_ready, pop_valid, pop_ready;
  fq_t  push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SPOT_X:         cfg.spot_x         <= cfg_data[COORD_BITS-1:0];
        REG_SPOT_Y:         cfg.spot_y         <= cfg_data[COORD_BITS-1:0];
        REG_INNER_RADIUS:   cfg.inner_radius   <= cfg_data[COORD_BITS-1:0];
        REG_OUTER_RADIUS:   cfg.outer_radius   <= cfg_data[COORD_BITS-1:0];
        REG_SPOT_RED:       cfg.spot_red       <= cfg_data[COL_W-1:0];
        REG_SPOT_GREEN:     cfg.spot_green     <= cfg_data[COL_W-1:0];
        REG_SPOT_BLUE:      cfg.spot_blue      <= cfg_data[COL_W-1:0];
        REG_BLEND_SUBTRACT: cfg.blend_subtract <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sbfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .beam_valid (beam_valid),
    .beam_ready (beam_ready),
    .beam       (beam),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sbfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sbfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_amount_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.falloff_amount <= AMT_ONE)
    else $error("falloff amount above full scale");

  a_clamp_low: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.new_red[ACC_W-1] |-> result.out_red == '0)
    else $error("negative red not clamped to zero");

  a_zero_amount: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.falloff_amount == '0 && !result.new_green[ACC_W-1]
      && result.new_green < ACC_W'(2 ** COL_W)
      |-> result.out_green == result.new_green[COL_W-1:0])
    else $error("green clamp mismatch");

endmodule

@@ tb/sv/tb_spot_beam_falloff_blend.sv @@
// Self-checking testbench of the spot beam falloff blend with directed and random beams.
module tb_spot_beam_falloff_blend;
  timeunit 1ns;
  timeprecision 1ps;
  import sbfb_pkg::*;

  localparam int LATENCY   = 80;
  localparam int N_RANDOM  = 1600;
  localparam int CYCLE_CAP = 900000;

  logic clk;
  logic rst;
  logic beam_valid;
  logic beam_ready;
  beam_t beam;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  cfg_t spot;
  result_t pending_results[$];
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  typedef struct {
    beam_t b;
    bit known;
    result_t r;
  } dir_row_t;
  dir_row_t dir_rows[$];

  spot_beam_falloff_blend u_top (
    .clk(clk), .rst(rst),
    .beam_valid(beam_valid), .beam_ready(beam_ready), .beam(beam),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned dist_q4(beam_t b);
    longint sa, sb, sc, sd, dot, len_sq, ddx, ddy, crs;
    logic [127:0] num;
    sa = longint'(spot.spot_x) - longint'(b.beam_start_x);
    sb = longint'(spot.spot_y) - longint'(b.beam_start_y);
    sc = longint'(b.beam_end_x) - longint'(b.beam_start_x);
    sd = longint'(b.beam_end_y) - longint'(b.beam_start_y);
    dot = sa * sc + sb * sd;
    len_sq = sc * sc + sd * sd;
    if (len_sq == 0 || dot <= 0) begin
      ddx = sa;
      ddy = sb;
    end else if (dot >= len_sq) begin
      ddx = longint'(spot.spot_x) - longint'(b.beam_end_x);
      ddy = longint'(spot.spot_y) - longint'(b.beam_end_y);
    end else begin
      crs = sa * sd - sb * sc;
      if (crs < 0) crs = -crs;
      num = (128'(crs) * 128'(crs)) << 8;
      return int_sqrt(64'(num / 128'(len_sq)));
    end
    return int_sqrt(64'(ddx * ddx + ddy * ddy) << 8);
  endfunction

  function automatic result_t blend_beam(beam_t b);
    result_t r;
    longint unsigned d4, ri, ro, amt;
    longint acc[3], colr[3], sc, nv;
    d4 = dist_q4(b);
    ri = longint'(spot.inner_radius) << 4;
    ro = longint'(spot.outer_radius) << 4;
    if (d4 < ri) amt = 256;
    else if (d4 > ro) amt = 0;
    else if (ro == ri) amt = 256;
    else amt = (256 * (ro - d4)) / (ro - ri);
    acc[0] = longint'(b.acc_red);
    acc[1] = longint'(b.acc_green);
    acc[2] = longint'(b.acc_blue);
    colr[0] = longint'(spot.spot_red);
    colr[1] = longint'(spot.spot_green);
    colr[2] = longint'(spot.spot_blue);
    r.falloff_amount = AMT_W'(amt);
    for (int k = 0; k < 3; k++) begin
      sc = (colr[k] * longint'(amt)) >>> 8;
      nv = spot.blend_subtract ? acc[k] - sc : acc[k] + sc;
      if (nv > 2047) nv = 2047;
      if (nv < -2048) nv = -2048;
      acc[k] = nv;
      colr[k] = nv > 255 ? 255 : (nv < 0 ? 0 : nv);
    end
    r.new_red = ACC_W'(acc[0]);
    r.new_green = ACC_W'(acc[1]);
    r.new_blue = ACC_W'(acc[2]);
    r.out_red = COL_W'(colr[0]);
    r.out_green = COL_W'(colr[1]);
    r.out_blue = COL_W'(colr[2]);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", result);
      end else begin
        want = pending_results.pop_front();
        if (want !== result) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, result);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPOT_X: spot.spot_x = val;
      REG_SPOT_Y: spot.spot_y = val;
      REG_INNER_RADIUS: spot.inner_radius = val;
      REG_OUTER_RADIUS: spot.outer_radius = val;
      REG_SPOT_RED: spot.spot_red = val[7:0];
      REG_SPOT_GREEN: spot.spot_green = val[7:0];
      REG_SPOT_BLUE: spot.spot_blue = val[7:0];
      default: spot.blend_subtract = val[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(cfg_t c);
    write_reg(REG_SPOT_X, c.spot_x);
    write_reg(REG_SPOT_Y, c.spot_y);
    write_reg(REG_INNER_RADIUS, c.inner_radius);
    write_reg(REG_OUTER_RADIUS, c.outer_radius);
    write_reg(REG_SPOT_RED, DATA_W'(c.spot_red));
    write_reg(REG_SPOT_GREEN, DATA_W'(c.spot_green));
    write_reg(REG_SPOT_BLUE, DATA_W'(c.spot_blue));
    write_reg(REG_BLEND_SUBTRACT, DATA_W'(c.blend_subtract));
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Called at a falling edge; returns at a falling edge after the beat is taken.
  task automatic send_beam(beam_t b, bit known, result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      beam_valid <= 1'b0;
      @(negedge clk);
    end
    beam_valid <= 1'b1;
    beam <= b;
    @(posedge clk);
    while (!beam_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), known ? r : blend_beam(b));
    @(negedge clk);
  endtask

  function automatic beam_t rand_beam(int span);
    beam_t b;
    int cx, cy;
    cx = $urandom_range(2047);
    cy = $urandom_range(2047);
    b.beam_start_x = COORD_BITS'((span == 0) ? $urandom_range(2047)
                                            : (cx + $urandom_range(span)) % 2048);
    b.beam_start_y = COORD_BITS'((span == 0) ? $urandom_range(2047)
                                            : (cy + $urandom_range(span)) % 2048);
    b.beam_end_x = COORD_BITS'((span == 0) ? $urandom_range(2047)
                                          : (cx + $urandom_range(span)) % 2048);
    b.beam_end_y = COORD_BITS'((span == 0) ? $urandom_range(2047)
                                          : (cy + $urandom_range(span)) % 2048);
    b.acc_red = ACC_W'($urandom);
    b.acc_green = ACC_W'($urandom);
    b.acc_blue = ($urandom_range(3) == 0) ? ACC_W'($urandom) : ACC_W'($urandom_range(300));
    return b;
  endfunction

  function automatic cfg_t rand_setting();
    cfg_t c;
    c.spot_x = COORD_BITS'($urandom_range(2047));
    c.spot_y = COORD_BITS'($urandom_range(2047));
    c.inner_radius = COORD_BITS'($urandom_range(3) == 0 ? $urandom_range(2047)
                                                      : $urandom_range(300));
    c.outer_radius = COORD_BITS'($urandom_range(3) == 0 ? $urandom_range(2047)
                                                      : $urandom_range(900));
    c.spot_red = COL_W'($urandom_range(255));
    c.spot_green = COL_W'($urandom_range(255));
    c.spot_blue = COL_W'($urandom_range(255));
    c.blend_subtract = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic beam_t mk(int sx, int sy, int ex, int ey, int ar, int ag, int ab);
    beam_t b;
    b.beam_start_x = COORD_BITS'(sx);
    b.beam_start_y = COORD_BITS'(sy);
    b.beam_end_x = COORD_BITS'(ex);
    b.beam_end_y = COORD_BITS'(ey);
    b.acc_red = ACC_W'(ar);
    b.acc_green = ACC_W'(ag);
    b.acc_blue = ACC_W'(ab);
    return b;
  endfunction

  function automatic result_t rk(int amt, int nr, int ng, int nb, int orr, int og, int ob);
    result_t r;
    r.falloff_amount = AMT_W'(amt);
    r.new_red = ACC_W'(nr);
    r.new_green = ACC_W'(ng);
    r.new_blue = ACC_W'(nb);
    r.out_red = COL_W'(orr);
    r.out_green = COL_W'(og);
    r.out_blue = COL_W'(ob);
    return r;
  endfunction

  task automatic add_row(beam_t b, bit known, result_t r);
    dir_row_t row;
    row.b = b;
    row.known = known;
    row.r = r;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    cfg_t c;
    int phase;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    spot = '0;
    rst = 1'b1;
    beam_valid = 1'b0;
    beam = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: zero radii at the spot itself give full amount, zero spot colour.
    add_row(mk(0, 0, 0, 0, 100, -5, 300), 1, rk(256, 100, -5, 300, 100, 0, 255));
    add_row(mk(2047, 2047, 2047, 2047, 2047, -2048, 0), 1,
            rk(0, 2047, -2048, 0, 255, 0, 0));
    foreach (dir_rows[i]) send_beam(dir_rows[i].b, dir_rows[i].known, dir_rows[i].r);
    dir_rows.delete();
    beam_valid <= 1'b0;
    drain();

    // Full white spot, add mode, radii 10 and 20, centre at 100,100.
    c = '0;
    c.spot_x = 100; c.spot_y = 100; c.inner_radius = 10; c.outer_radius = 20;
    c.spot_red = 255; c.spot_green = 255; c.spot_blue = 255;
    load_setting(c);
    add_row(mk(100, 100, 100, 100, 2047, 0, -2048), 1,
            rk(256, 2047, 255, -1793, 255, 255, 0));
    add_row(mk(2047, 2047, 2047, 2047, 0, 0, 0), 1, rk(0, 0, 0, 0, 0, 0, 0));
    add_row(mk(0, 100, 2047, 100, 0, 0, 0), 1, rk(256, 255, 255, 255, 255, 255, 255));
    add_row(mk(115, 0, 115, 2047, 0, 0, 0), 0, '0);
    add_row(mk(50, 100, 80, 100, 0, 0, 0), 1, rk(0, 0, 0, 0, 0, 0, 0));
    add_row(mk(80, 100, 50, 100, -100, 0, 0), 0, '0);
    add_row(mk(130, 100, 160, 100, 0, 0, 0), 0, '0);
    add_row(mk(112, 90, 112, 110, 0, 0, 0), 0, '0);
    add_row(mk(0, 0, 2047, 2047, 7, 7, 7), 0, '0);
    foreach (dir_rows[i]) send_beam(dir_rows[i].b, dir_rows[i].known, dir_rows[i].r);
    dir_rows.delete();
    beam_valid <= 1'b0;
    drain();

    // Subtract mode, equal radii, then inner above outer.
    c.blend_subtract = 1; c.inner_radius = 15; c.outer_radius = 15;
    load_setting(c);
    add_row(mk(100, 100, 100, 100, -2048, 0, 2047), 1,
            rk(256, -2048, -255, 1792, 0, 0, 255));
    add_row(mk(115, 100, 115, 100, 0, 0, 0), 0, '0);
    add_row(mk(116, 100, 116, 100, 0, 0, 0), 0, '0);
    foreach (dir_rows[i]) send_beam(dir_rows[i].b, dir_rows[i].known, dir_rows[i].r);
    dir_rows.delete();
    beam_valid <= 1'b0;
    drain();
    c.inner_radius = 2047; c.outer_radius = 3; c.spot_x = 2047; c.spot_y = 0;
    load_setting(c);
    add_row(mk(0, 2047, 0, 2047, 0, 0, 0), 0, '0);
    add_row(mk(0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(2047, 0, 0, 2047, 0, 0, 0), 0, '0);
    foreach (dir_rows[i]) send_beam(dir_rows[i].b, dir_rows[i].known, dir_rows[i].r);
    dir_rows.delete();
    beam_valid <= 1'b0;
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      c = rand_setting();
      if (phase == 7) begin
        c.inner_radius = 2047; c.outer_radius = 2047; c.spot_x = 2047; c.spot_y = 2047;
      end
      load_setting(c);
      for (int n = 0; n < N_RANDOM / 8; n++) begin
        if (n == 100 && phase == 1) begin
          beam_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        send_beam(rand_beam($urandom_range(2) == 0 ? 0 : $urandom_range(1, 600)), 0, '0);
      end
      beam_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/sbfb_pkg.sv
rtl/sbfb_front.sv
rtl/sbfb_queue.sv
rtl/sbfb_back.sv
rtl/spot_beam_falloff_blend.sv
tb/sv/tb_spot_beam_falloff_blend.sv
